### rtl/core/mp42_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp42_pkg: shared constants for the 4x4 stride-2 max pooling block
// Register indexes, field widths, reset defaults and result queue sizing.
// ----------------------------------------------------------------------------
package mp42_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int COORD_BITS   = 10;
  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 3;
  localparam int PAD_BITS     = 2;
  localparam int MAX_HEIGHT   = 1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_IN_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IN_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_TOP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_LEFT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_WIDTH  = 3'd5;

  // Register reset values.
  localparam logic [CFG_BITS-1:0] IN_HEIGHT_RST  = 11'd4;
  localparam logic [CFG_BITS-1:0] IN_WIDTH_RST   = 11'd4;
  localparam logic [CFG_BITS-1:0] OUT_HEIGHT_RST = 11'd1;
  localparam logic [CFG_BITS-1:0] OUT_WIDTH_RST  = 11'd1;

  // One pixel can close at most four windows.
  localparam int MAX_RESULTS    = 4;
  localparam int RES_FIFO_DEPTH = 16;

endpackage

### rtl/core/max_pool_4x4_stride2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_4x4_stride2: streaming 2-D max pooling, 4x4 window, stride 2
// Raster-order pixels in, window maxima with output coordinates out.
// ----------------------------------------------------------------------------
// Dataflow: an accepted pixel and its line store read are registered in the
//   second stage; the window update there writes any result it closes into
//   the result queue, whose head is shown on out_*.
// Throughput: one pixel per cycle and one result per cycle; in_tready drops
//   only while the result queue, counting the results still coming from the
//   second stage, has fewer than four free entries.
// Reset: synchronous, active low; clears position, queue and config to
//   defaults. The line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module max_pool_4x4_stride2 #(
  parameter int MAX_WIDTH   = mp42_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = mp42_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [mp42_pkg::CFG_IDX_BITS-1:0]     cfg_addr,
  input  logic [mp42_pkg::CFG_BITS-1:0]         cfg_wdata,
  // Pixel stream.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // in_tdata fields from bit 0: pixel.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,
  // in_tuser fields from bit 0: frame_start.
  input  logic                                  in_tuser,
  // Result stream.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_tdata fields from bit 0: pooled_value, out_row, out_col.
  output logic [((SAMPLE_BITS+20+7)/8)*8-1:0]   out_tdata,
  // last_of_run: final result caused by one pixel.
  output logic                                  out_tlast
);
  import mp42_pkg::*;

  localparam int OUT_DW = ((SAMPLE_BITS + 20 + 7) / 8) * 8;
  // Column index width and a width that can hold the effective width itself.
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = CW + 1;
  // Width for padded coordinates and window indexes.
  localparam int XW = ((CW > CFG_BITS) ? CW : CFG_BITS) + 2;
  localparam int FW = $clog2(RES_FIFO_DEPTH);
  localparam int NR = MAX_RESULTS;

  typedef struct packed {
    logic                          last;
    logic [COORD_BITS-1:0]         col;
    logic [COORD_BITS-1:0]         row;
    logic signed [SAMPLE_BITS-1:0] value;
  } res_t;

  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration registers.
  logic [CFG_BITS-1:0] cfg_in_height_r, cfg_in_width_r;
  logic [CFG_BITS-1:0] cfg_out_height_r, cfg_out_width_r;
  logic [PAD_BITS-1:0] cfg_pad_top_r, cfg_pad_left_r;

  // Raster position of the next pixel.
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [CW-1:0]         col_r, col_nxt;

  // Second stage: the accepted pixel with its position.
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_pix_r;
  logic [COORD_BITS-1:0]         s1_row_r;
  logic [CW-1:0]                 s1_col_r;

  // Line stores of per-column vertical maxima, one per output row parity.
  logic signed [SAMPLE_BITS-1:0] line_even_mem [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] line_odd_mem  [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] rd_even_r, rd_odd_r;
  // Forwarding for a store write to the column read in the same cycle.
  logic                          byp_even_r, byp_odd_r;
  logic signed [SAMPLE_BITS-1:0] byp_even_d_r, byp_odd_d_r;

  // Horizontal running maxima, indexed [window column parity][row parity].
  logic signed [SAMPLE_BITS-1:0] hmax_r   [2][2];
  logic signed [SAMPLE_BITS-1:0] hmax_nxt [2][2];

  // Result queue.
  res_t            fifo_r [RES_FIFO_DEPTH];
  logic [FW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FW:0]     count_r, count_nxt;

  logic            in_acc, out_acc;
  logic [WW-1:0]   w_eff;
  logic [CFG_BITS-1:0] h_eff;
  logic [CW-1:0]   c0;
  logic [COORD_BITS-1:0] r0;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Effective image size: a zero register acts as one, and the width is
  // limited to the line store depth.
  always_comb begin
    if (cfg_in_width_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(cfg_in_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_in_width_r);
    end
    if (cfg_in_height_r == '0) begin
      h_eff = CFG_BITS'(1);
    end else if (int'(cfg_in_height_r) > MAX_HEIGHT) begin
      h_eff = CFG_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_in_height_r;
    end
  end

  // Position of the incoming pixel. A frame start restarts at the origin;
  // a position left outside the image by a size change wraps first.
  always_comb begin
    logic [CW-1:0]       col_s;
    logic [CFG_BITS-1:0] row_s;
    logic [WW-1:0]       col_inc;
    logic [CFG_BITS-1:0] row_inc;
    col_s = in_tuser ? '0 : col_r;
    row_s = in_tuser ? '0 : CFG_BITS'(row_r);
    if (WW'(col_s) >= w_eff) begin
      col_s = '0;
      row_s = row_s + 1'b1;
    end
    if (row_s >= h_eff) begin
      row_s = '0;
    end
    c0 = col_s;
    r0 = row_s[COORD_BITS-1:0];
    col_inc = WW'(c0) + 1'b1;
    row_inc = CFG_BITS'(r0) + 1'b1;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[COORD_BITS-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = r0;
    end
  end

  // Second stage. Each pixel belongs to at most two window rows and two
  // window columns; slot 0 is the lower index, slot 1 the higher. The two
  // window rows differ in parity, so each line store sees one update.
  logic [XW-1:0]                 t_s1, u_s1;
  logic [XW-1:0]                 oh_q [2];
  logic [XW-1:0]                 ow_q [2];
  logic                          oh_v [2];
  logic                          ow_v [2];
  logic signed [SAMPLE_BITS-1:0] rd_even, rd_odd;
  logic signed [SAMPLE_BITS-1:0] line_new [2];
  logic signed [SAMPLE_BITS-1:0] hval [NR];
  logic [NR-1:0]                 emit_q;
  logic                          we_even, we_odd;
  logic signed [SAMPLE_BITS-1:0] wd_even, wd_odd;

  assign rd_even = byp_even_r ? byp_even_d_r : rd_even_r;
  assign rd_odd  = byp_odd_r  ? byp_odd_d_r  : rd_odd_r;

  always_comb begin
    logic                          row_first, col_first, row_last, col_last;
    logic                          row_end;
    logic signed [SAMPLE_BITS-1:0] line_old, hold, hv;
    t_s1 = XW'(s1_row_r) + XW'(cfg_pad_top_r);
    u_s1 = XW'(s1_col_r) + XW'(cfg_pad_left_r);
    oh_q[1] = t_s1 >> 1;
    oh_q[0] = oh_q[1] - 1'b1;
    oh_v[1] = 1'b1;
    oh_v[0] = (t_s1 >= XW'(2));
    ow_q[1] = u_s1 >> 1;
    ow_q[0] = ow_q[1] - 1'b1;
    ow_v[1] = 1'b1;
    ow_v[0] = (u_s1 >= XW'(2));
    row_first = (s1_row_r == '0);
    col_first = (s1_col_r == '0);
    row_last  = ((CFG_BITS'(s1_row_r) + 1'b1) == h_eff);
    col_last  = ((WW'(s1_col_r) + 1'b1) == w_eff);
    we_even = 1'b0;
    we_odd  = 1'b0;
    wd_even = s1_pix_r;
    wd_odd  = s1_pix_r;
    hmax_nxt = hmax_r;
    emit_q = '0;
    for (int i = 0; i < 2; i++) begin
      line_old = oh_q[i][0] ? rd_odd : rd_even;
      // The first row of the image or of this window restarts the column max.
      if (row_first || (t_s1 == (oh_q[i] << 1))) begin
        line_new[i] = s1_pix_r;
      end else begin
        line_new[i] = (s1_pix_r > line_old) ? s1_pix_r : line_old;
      end
      if (oh_v[i]) begin
        if (oh_q[i][0]) begin
          we_odd = s1_valid_r;
          wd_odd = line_new[i];
        end else begin
          we_even = s1_valid_r;
          wd_even = line_new[i];
        end
      end
      row_end = (t_s1 == ((oh_q[i] << 1) + XW'(3))) || row_last;
      for (int j = 0; j < 2; j++) begin
        hold = hmax_r[ow_q[j][0]][oh_q[i][0]];
        if (col_first || (u_s1 == (ow_q[j] << 1))) begin
          hv = line_new[i];
        end else begin
          hv = (line_new[i] > hold) ? line_new[i] : hold;
        end
        hval[i*2+j] = hv;
        if (oh_v[i] && ow_v[j]) begin
          hmax_nxt[ow_q[j][0]][oh_q[i][0]] = hv;
        end
        emit_q[i*2+j] = oh_v[i] && ow_v[j] && row_end &&
                        ((u_s1 == ((ow_q[j] << 1) + XW'(3))) || col_last) &&
                        (oh_q[i] < XW'(cfg_out_height_r)) &&
                        (ow_q[j] < XW'(cfg_out_width_r));
      end
    end
  end

  // Pack the emitted results in order and mark the last of the run.
  logic [NR-1:0] emit_push, last_q;
  logic [2:0]    push_n;
  logic [FW-1:0] wr_addr [NR];
  res_t          res_q [NR];

  always_comb begin
    logic [2:0] cnt;
    logic       seen;
    emit_push = s1_valid_r ? emit_q : '0;
    cnt  = '0;
    seen = 1'b0;
    for (int q = NR - 1; q >= 0; q--) begin
      last_q[q] = emit_push[q] && !seen;
      seen = seen || emit_push[q];
    end
    for (int q = 0; q < NR; q++) begin
      wr_addr[q] = wr_ptr_r + FW'(cnt);
      if (emit_push[q]) begin
        cnt = cnt + 1'b1;
      end
      res_q[q].last  = last_q[q];
      res_q[q].col   = ow_q[q % 2][COORD_BITS-1:0];
      res_q[q].row   = oh_q[q / 2][COORD_BITS-1:0];
      res_q[q].value = hval[q];
    end
    push_n = cnt;
  end

  // A new pixel is taken only if the queue can hold the results still to
  // come from the pixel in the second stage and four more.
  assign in_tready = (int'(count_r) + int'(push_n)) <= (RES_FIFO_DEPTH - NR);

  assign count_nxt = count_r + (FW+1)'(push_n) - (FW+1)'(out_acc);

  assign out_tvalid = (count_r != '0);
  assign out_tdata  = OUT_DW'({fifo_r[rd_ptr_r].col, fifo_r[rd_ptr_r].row,
                               fifo_r[rd_ptr_r].value});
  assign out_tlast  = fifo_r[rd_ptr_r].last;

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_in_height_r  <= IN_HEIGHT_RST;
      cfg_in_width_r   <= IN_WIDTH_RST;
      cfg_pad_top_r    <= '0;
      cfg_pad_left_r   <= '0;
      cfg_out_height_r <= OUT_HEIGHT_RST;
      cfg_out_width_r  <= OUT_WIDTH_RST;
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
      byp_even_r <= 1'b0;
      byp_odd_r  <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
      for (int a = 0; a < 2; a++) begin
        for (int b = 0; b < 2; b++) begin
          hmax_r[a][b] <= MOST_NEG;
        end
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_IN_HEIGHT:  cfg_in_height_r  <= cfg_wdata;
          REG_IN_WIDTH:   cfg_in_width_r   <= cfg_wdata;
          REG_PAD_TOP:    cfg_pad_top_r    <= cfg_wdata[PAD_BITS-1:0];
          REG_PAD_LEFT:   cfg_pad_left_r   <= cfg_wdata[PAD_BITS-1:0];
          REG_OUT_HEIGHT: cfg_out_height_r <= cfg_wdata;
          REG_OUT_WIDTH:  cfg_out_width_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      s1_valid_r <= in_acc;
      if (in_acc) begin
        row_r      <= row_nxt;
        col_r      <= col_nxt;
        byp_even_r <= we_even && (s1_col_r == c0);
        byp_odd_r  <= we_odd && (s1_col_r == c0);
      end
      if (s1_valid_r) begin
        hmax_r <= hmax_nxt;
      end
      wr_ptr_r <= wr_ptr_r + FW'(push_n);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r     <= in_tdata[SAMPLE_BITS-1:0];
      s1_row_r     <= r0;
      s1_col_r     <= c0;
      byp_even_d_r <= wd_even;
      byp_odd_d_r  <= wd_odd;
    end
    for (int q = 0; q < NR; q++) begin
      if (emit_push[q]) begin
        fifo_r[wr_addr[q]] <= res_q[q];
      end
    end
  end

  // Line stores: read at the accepted column, written back in the following cycle.
  always_ff @(posedge clk) begin
    if (we_even) begin
      line_even_mem[s1_col_r] <= wd_even;
    end
    if (in_acc) begin
      rd_even_r <= line_even_mem[c0];
    end
  end

  always_ff @(posedge clk) begin
    if (we_odd) begin
      line_odd_mem[s1_col_r] <= wd_odd;
    end
    if (in_acc) begin
      rd_odd_r <= line_odd_mem[c0];
    end
  end

  // The admission rule keeps the result queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((int'(count_r) + int'(push_n)) <= RES_FIFO_DEPTH))
    else $error("result queue overflow");

  // After a pixel transaction the stored position lies inside the image.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_acc) && !$past(cfg_we)) |->
      ((WW'(col_r) < w_eff) && (CFG_BITS'(row_r) < h_eff)))
    else $error("raster position outside image");

  // Exactly one result of a non-empty run carries the last flag.
  a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ($countones(last_q) == ((emit_push != '0) ? 1 : 0)))
    else $error("run end flag count wrong");

endmodule
